FILE: design/sexpr_token_splitter_core_defines.svh
// assertion macros shared by the checker of the token splitter
// no dependencies; included by the checker file
`ifndef SEXPR_TOKEN_SPLITTER_CORE_DEFINES_SVH
`define SEXPR_TOKEN_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define STS_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define STS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/sts_pkg.sv
// shared types, codes and character constants of the token splitter
// no dependencies
package sts_pkg;

	// scan modes, one-hot
	typedef enum logic [4:0] {
		MODE_NORMAL  = 5'b00001,
		MODE_ESC     = 5'b00010,
		MODE_STR     = 5'b00100,
		MODE_STR_ESC = 5'b01000,
		MODE_COMMENT = 5'b10000
	} scan_mode_t;

	// event kinds seen on the result channel
	typedef enum logic [2:0] {
		EV_SYMCHAR = 3'd0,
		EV_SYMEND  = 3'd1,
		EV_PUNCT   = 3'd2,
		EV_END     = 3'd3,
		EV_ERR_ESC = 3'd4,
		EV_ERR_STR = 3'd5
	} ev_kind_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	typedef struct packed {
		logic       stream_done;
		logic [7:0] char_in;
	} src_item_t;

	typedef struct packed {
		ev_kind_t   event_kind;
		logic [7:0] event_byte;
		logic       final_of_run;
	} evt_item_t;

	// decoder result for one input item
	typedef struct packed {
		logic [1:0] count;
		evt_item_t  ev0;
		evt_item_t  ev1;
		scan_mode_t next_mode;
		logic       next_open;
	} dec_t;

	function automatic evt_item_t mk_event(ev_kind_t kind, logic [7:0] b);
		evt_item_t e;
		e.event_kind   = kind;
		e.event_byte   = b;
		e.final_of_run = 1'b0;
		return e;
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		logic r;
		case (c)
			8'h28, 8'h29, 8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h3c, 8'h3e,
			8'h2e, 8'h24, 8'h3a, 8'h23, 8'h40: r = 1'b1;
			default:                            r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
	endfunction

endpackage

FILE: design/sts_decode.sv
// per-item decoder: events and next scan state for one input item
// depends on sts_pkg
module sts_decode
	import sts_pkg::*;
(
	input  src_item_t  item,
	input  scan_mode_t mode,
	input  logic       open,
	output dec_t       dec
);

	logic [7:0] c;
	assign c = item.char_in;

	always_comb begin
		dec.count     = 2'd0;
		dec.ev0       = mk_event(EV_SYMCHAR, 8'h00);
		dec.ev1       = mk_event(EV_SYMCHAR, 8'h00);
		dec.next_mode = mode;
		dec.next_open = open;

		if (item.stream_done) begin
			dec.next_mode = MODE_NORMAL;
			dec.next_open = 1'b0;
			if (mode == MODE_ESC || mode == MODE_STR_ESC) begin
				dec.ev0   = mk_event(EV_ERR_ESC, 8'h00);
				dec.count = 2'd1;
			end else if (mode == MODE_STR) begin
				dec.ev0   = mk_event(EV_ERR_STR, 8'h00);
				dec.count = 2'd1;
			end else if (open) begin
				dec.ev0   = mk_event(EV_SYMEND, 8'h00);
				dec.ev1   = mk_event(EV_END, 8'h00);
				dec.count = 2'd2;
			end else begin
				dec.ev0   = mk_event(EV_END, 8'h00);
				dec.count = 2'd1;
			end
		end else begin
			case (mode)
				MODE_ESC: begin
					dec.ev0       = mk_event(EV_SYMCHAR, c);
					dec.count     = 2'd1;
					dec.next_open = 1'b1;
					dec.next_mode = MODE_NORMAL;
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						dec.next_mode = MODE_NORMAL;
						dec.next_open = 1'b0;
						if (open) begin
							dec.ev0   = mk_event(EV_SYMEND, 8'h00);
							dec.count = 2'd1;
						end
					end else if (c == CH_BSLASH) begin
						dec.next_mode = MODE_STR_ESC;
					end else begin
						dec.ev0       = mk_event(EV_SYMCHAR, c);
						dec.count     = 2'd1;
						dec.next_open = 1'b1;
					end
				end
				MODE_STR_ESC: begin
					dec.ev0       = mk_event(EV_SYMCHAR, c);
					dec.count     = 2'd1;
					dec.next_open = 1'b1;
					dec.next_mode = MODE_STR;
				end
				MODE_COMMENT: begin
					if (c == CH_LF || c == CH_CR)
						dec.next_mode = MODE_NORMAL;
				end
				default: begin
					dec.next_mode = MODE_NORMAL;
					if (is_punct(c)) begin
						dec.next_open = 1'b0;
						if (open) begin
							dec.ev0   = mk_event(EV_SYMEND, 8'h00);
							dec.ev1   = mk_event(EV_PUNCT, c);
							dec.count = 2'd2;
						end else begin
							dec.ev0   = mk_event(EV_PUNCT, c);
							dec.count = 2'd1;
						end
					end else if (is_space(c) || c == CH_SEMI || c == CH_QUOTE) begin
						dec.next_open = 1'b0;
						if (open) begin
							dec.ev0   = mk_event(EV_SYMEND, 8'h00);
							dec.count = 2'd1;
						end
						if (c == CH_SEMI)
							dec.next_mode = MODE_COMMENT;
						else if (c == CH_QUOTE)
							dec.next_mode = MODE_STR;
					end else if (c == CH_BSLASH) begin
						dec.next_mode = MODE_ESC;
					end else begin
						dec.ev0       = mk_event(EV_SYMCHAR, c);
						dec.count     = 2'd1;
						dec.next_open = 1'b1;
					end
				end
			endcase
		end

		dec.ev0.final_of_run = (dec.count == 2'd1);
		dec.ev1.final_of_run = 1'b1;
	end

endmodule

FILE: design/sts_out_stage.sv
// result register of the token splitter, one event per cycle unless stalled
// depends on sts_pkg
module sts_out_stage
	import sts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load_valid,
	input  evt_item_t load_item,
	output logic      load_ready,
	output logic      valid,
	input  logic      stall,
	output evt_item_t item
);

	logic      valid_q;
	evt_item_t item_q;

	// register frees up in the same cycle its item is taken
	assign load_ready = !valid_q || !stall;
	assign valid      = valid_q;
	assign item       = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			item_q <= load_item;
		end
	end

endmodule

FILE: design/sexpr_token_splitter_core.sv
// s-expression token splitter: input register, decoder, result register
// depends on sts_pkg, sts_decode, sts_out_stage
//
// usage
//   src channel: one source byte per item (char_in), or an end marker
//     (stream_done high, char_in ignored)
//   evt channel: token events; final_of_run marks the last event of an item
//   an item causes zero, one or two events
// path: an item is registered at the input and decoded in the cycle after;
//   its first event is loaded into the result register once that register
//   can take it, and evt_valid then offers that event
// throughput: one item per cycle when it makes at most one event and no
//   stall holds evt; an item that makes two events holds the input register
//   until both are loaded, as the result register takes one event per cycle
// items that make no event (whitespace alone, comment bytes, backslash)
//   retire without touching the result register, even while it is stalled
// reset: scan mode returns to normal, no symbol pending, both registers empty
// stall on evt: the result register holds its event; the decoder waits, and
//   src_stall rises once the input register holds an item it cannot retire
module sexpr_token_splitter_core
	import sts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_item,
	output logic      evt_valid,
	input  logic      evt_stall,
	output evt_item_t evt_item
);

	// input register
	logic      valid_s1;
	src_item_t item_s1;

	// scanner state, updated when an item retires
	scan_mode_t mode_q;
	logic       open_q;
	// which event of a two-event item goes out next
	logic       phase_q;

	dec_t      dec;
	evt_item_t sel_ev;
	logic      out_ready;
	logic      emit;
	logic      retire;

	sts_decode u_decode (
		.item (item_s1),
		.mode (mode_q),
		.open (open_q),
		.dec  (dec)
	);

	assign sel_ev = phase_q ? dec.ev1 : dec.ev0;

	// one event leaves per cycle when the result register can take it
	assign emit = valid_s1 && (dec.count != 2'd0) && out_ready;

	// item done: no events at all, or its last event is being loaded
	assign retire = valid_s1 && ((dec.count == 2'd0) ||
		(out_ready && (phase_q == (dec.count == 2'd2))));

	// input side waits only while the held item cannot retire this cycle
	assign src_stall = valid_s1 && !retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			item_s1 <= src_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			open_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (retire) begin
			mode_q  <= dec.next_mode;
			open_q  <= dec.next_open;
			phase_q <= 1'b0;
		end else if (emit) begin
			// first of two events went out
			phase_q <= 1'b1;
		end
	end

	sts_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (emit),
		.load_item  (sel_ev),
		.load_ready (out_ready),
		.valid      (evt_valid),
		.stall      (evt_stall),
		.item       (evt_item)
	);

endmodule

FILE: design/sts_checker.sv
// port-level checks of the token splitter, bound to the top level
// depends on sts_pkg and sexpr_token_splitter_core_defines.svh
`include "sexpr_token_splitter_core_defines.svh"

module sts_checker
	import sts_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      evt_valid,
	input logic      evt_stall,
	input evt_item_t evt_item
);

	// a stalled event stays offered
	`STS_ASSERT_NEXT(a_evt_hold, evt_valid && evt_stall, evt_valid)

	// only a symbol end can be followed by another event of the same item
	`STS_ASSERT_NOW(a_nonfinal_symend, evt_valid && !evt_item.final_of_run,
		evt_item.event_kind == EV_SYMEND)

	// the second event of a pair comes right after the first is taken
	`STS_ASSERT_NEXT(a_pair_follows, evt_valid && !evt_stall && !evt_item.final_of_run,
		evt_valid && (evt_item.event_kind == EV_PUNCT || evt_item.event_kind == EV_END))

	// only symbol chars and punctuation carry a byte
	`STS_ASSERT_NOW(a_byte_zero, evt_valid && evt_item.event_kind != EV_SYMCHAR &&
		evt_item.event_kind != EV_PUNCT, evt_item.event_byte == 8'h00)

endmodule

bind sexpr_token_splitter_core sts_checker u_sts_checker (.*);
